### rtl/core/ctd_pkg.sv
// Package for the capacitive touch detector: shared types, event codes,
// command codes and register indexes. No dependencies.
package ctd_pkg;

    localparam int SUM_W       = 12;
    localparam int SAMPLE_W    = 8;
    localparam int PAD_W       = 3;
    localparam int BASE_W      = 16;
    localparam int HOLD_W      = 8;
    localparam int THRESH_W    = 12;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int EVENT_W     = 3;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_ON_THRESHOLD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT    = 2'd2;

    // Reset values of the registers
    localparam logic [THRESH_W-1:0] ON_THRESHOLD_RST  = 12'd2;
    localparam logic [THRESH_W-1:0] OFF_THRESHOLD_RST = 12'd1;
    localparam logic [HOLD_W-1:0]   HOLD_LIMIT_RST    = 8'd255;

    localparam logic CMD_SENSE     = 1'b0;
    localparam logic CMD_CALIBRATE = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_OFF     = 3'd0,
        EV_ON      = 3'd1,
        EV_PUSH    = 3'd2,
        EV_RELEASE = 3'd3,
        EV_TIMEOUT = 3'd4
    } event_t;

    typedef struct packed {
        logic [BASE_W-1:0] baseline;
        logic              touched;
        logic [HOLD_W-1:0] hold_count;
    } pad_state_t;

    typedef struct packed {
        logic [THRESH_W-1:0] on_threshold;
        logic [THRESH_W-1:0] off_threshold;
        logic [HOLD_W-1:0]   hold_limit;
    } cfg_t;

    typedef struct packed {
        logic       wr_en;
        pad_state_t next_state;
        event_t     event_code;
    } eval_res_t;

endpackage

### rtl/core/ctd_if.sv
// Channel interfaces for the capacitive touch detector: sense input,
// event output and configuration write. Depends on ctd_pkg.
interface ctd_in_if;
    logic                           valid;
    logic                           ready;
    logic                           command;
    logic [ctd_pkg::PAD_W-1:0]      pad;
    logic [ctd_pkg::SUM_W-1:0]      sample_sum;
    logic [ctd_pkg::SAMPLE_W-1:0]   fresh_sample;

    modport source (output valid, command, pad, sample_sum, fresh_sample, input ready);
    modport sink   (input valid, command, pad, sample_sum, fresh_sample, output ready);
endinterface

interface ctd_out_if;
    logic                           valid;
    logic                           ready;
    logic [ctd_pkg::PAD_W-1:0]      pad_out;
    logic [ctd_pkg::EVENT_W-1:0]    event_res;

    modport source (output valid, pad_out, event_res, input ready);
    modport sink   (input valid, pad_out, event_res, output ready);
endinterface

interface ctd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ctd_pkg::CFG_INDEX_W-1:0]  index;
    logic [ctd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/ctd_state.sv
// Per-pad state store: baseline, touched flag and hold counter in flops.
// One read and one write port. Depends on ctd_pkg.
module ctd_state #(
    parameter int NUM_PADS = 8,
    localparam int IDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    rd_idx,
    output ctd_pkg::pad_state_t rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_idx,
    input  ctd_pkg::pad_state_t wr_data
);

    ctd_pkg::pad_state_t state_reg [NUM_PADS];

    assign rd_data = state_reg[rd_idx];

    // Clear all pads on reset; write back one pad per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PADS; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            state_reg[wr_idx] <= wr_data;
        end
    end

endmodule

### rtl/core/ctd_eval.sv
// Touch decision logic: compares the sample sum with the pad baseline and
// forms the event and the pad's next state. Depends on ctd_pkg.
module ctd_eval (
    input  logic                              command,
    input  logic                              in_range,
    input  logic [ctd_pkg::SUM_W-1:0]         sample_sum,
    input  logic [ctd_pkg::SAMPLE_W-1:0]      fresh_sample,
    input  ctd_pkg::pad_state_t               cur_state,
    input  ctd_pkg::cfg_t                     cfg,
    output ctd_pkg::eval_res_t                res
);

    logic signed [ctd_pkg::SUM_W+1:0] delta;
    logic                             above_on;
    logic                             below_off;
    logic                             hold_hit;
    logic [ctd_pkg::BASE_W:0]         iir_sum;
    logic [ctd_pkg::BASE_W-1:0]       cal_base;

    // delta = sum - baseline/16, signed
    assign delta     = $signed({2'b00, sample_sum}) - $signed({2'b00, cur_state.baseline[15:4]});
    assign above_on  = delta > $signed({2'b00, cfg.on_threshold});
    assign below_off = delta < $signed({2'b00, cfg.off_threshold});
    assign hold_hit  = (cfg.hold_limit != '0) && (cur_state.hold_count == cfg.hold_limit);

    // Low pass: b - b/64 + sum/4, kept to 16 bits
    assign iir_sum  = {1'b0, cur_state.baseline} - {7'b0, cur_state.baseline[15:6]}
                    + {7'b0, sample_sum[11:2]};
    assign cal_base = {fresh_sample, 8'h00};

    always_comb
    begin
        res.wr_en      = in_range;
        res.next_state = cur_state;
        res.event_code = ctd_pkg::EV_OFF;
        if (command == ctd_pkg::CMD_CALIBRATE)
        begin
            res.next_state.baseline = cal_base;
            res.next_state.touched  = 1'b0;
        end
        else if (!cur_state.touched)
        begin
            if (above_on)
            begin
                res.next_state.touched    = 1'b1;
                res.next_state.hold_count = '0;
                res.event_code            = ctd_pkg::EV_PUSH;
            end
            else
            begin
                res.next_state.baseline = iir_sum[ctd_pkg::BASE_W-1:0];
            end
        end
        else if (below_off)
        begin
            res.next_state.touched = 1'b0;
            res.event_code         = ctd_pkg::EV_RELEASE;
        end
        else if (hold_hit)
        begin
            res.next_state.baseline = cal_base;
            res.event_code          = ctd_pkg::EV_TIMEOUT;
        end
        else
        begin
            res.next_state.hold_count = cur_state.hold_count + 8'd1;
            res.event_code            = ctd_pkg::EV_ON;
        end
        // Pads beyond the store report off and change nothing
        if (!in_range)
        begin
            res.event_code = ctd_pkg::EV_OFF;
        end
    end

endmodule

### rtl/core/capacitive_touch_detector_unit.sv
// Top level of the multi-pad capacitive touch detector.
// Depends on ctd_pkg, ctd_if, ctd_state and ctd_eval.
//
// The detector takes one sense or calibrate word per clock cycle unless the
// output stalls, and returns exactly one event word per input word, in order,
// via an input and an output register. A word is held in the input register,
// where the addressed pad's state is read from a flop store, evaluated and
// written back in the same cycle that the event moves to the output register;
// this single read-modify-write of the pad store sets the one-word-per-cycle
// rate, and a word for the same pad in the next cycle sees the updated state.
// The output register parts the two sides, so a new word can be taken while
// an event waits. Configuration writes are always taken (ready stays high) and
// belong to idle periods only; an index past the last register is dropped.
module capacitive_touch_detector_unit #(
    parameter int NUM_PADS = 8
) (
    input logic      clk,
    input logic      rst_n,
    ctd_in_if.sink   item,
    ctd_out_if.source result,
    ctd_cfg_if.sink  cfg
);

    localparam int IDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

    // Configuration registers
    ctd_pkg::cfg_t cfg_reg;

    // Input stage
    logic                           s1_valid_reg;
    logic                           s1_cmd_reg;
    logic [ctd_pkg::PAD_W-1:0]      s1_pad_reg;
    logic [ctd_pkg::SUM_W-1:0]      s1_sum_reg;
    logic [ctd_pkg::SAMPLE_W-1:0]   s1_fresh_reg;

    // Output stage
    logic                           out_valid_reg;
    logic [ctd_pkg::PAD_W-1:0]      out_pad_reg;
    ctd_pkg::event_t                out_event_reg;

    logic                           s1_fire;
    logic                           in_fire;
    logic                           in_range;
    logic [IDX_W-1:0]               pad_idx;
    ctd_pkg::pad_state_t            cur_state;
    ctd_pkg::eval_res_t             eval_res;

    // Advance the input stage whenever the output slot is free or draining
    assign s1_fire  = s1_valid_reg && (!out_valid_reg || result.ready);
    assign in_fire  = item.valid && item.ready;
    assign item.ready = !s1_valid_reg || s1_fire;

    assign in_range = 32'(s1_pad_reg) < NUM_PADS;
    assign pad_idx  = IDX_W'(s1_pad_reg);

    assign cfg.ready        = 1'b1;
    assign result.valid     = out_valid_reg;
    assign result.pad_out   = out_pad_reg;
    assign result.event_res = out_event_reg;

    ctd_state #(
        .NUM_PADS (NUM_PADS)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (pad_idx),
        .rd_data (cur_state),
        .wr_en   (s1_fire && eval_res.wr_en),
        .wr_idx  (pad_idx),
        .wr_data (eval_res.next_state)
    );

    ctd_eval u_eval (
        .command      (s1_cmd_reg),
        .in_range     (in_range),
        .sample_sum   (s1_sum_reg),
        .fresh_sample (s1_fresh_reg),
        .cur_state    (cur_state),
        .cfg          (cfg_reg),
        .res          (eval_res)
    );

    // Configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_threshold  <= ctd_pkg::ON_THRESHOLD_RST;
            cfg_reg.off_threshold <= ctd_pkg::OFF_THRESHOLD_RST;
            cfg_reg.hold_limit    <= ctd_pkg::HOLD_LIMIT_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                ctd_pkg::REG_ON_THRESHOLD:  cfg_reg.on_threshold  <= cfg.data;
                ctd_pkg::REG_OFF_THRESHOLD: cfg_reg.off_threshold <= cfg.data;
                ctd_pkg::REG_HOLD_LIMIT:
                    cfg_reg.hold_limit <= cfg.data[ctd_pkg::HOLD_W-1:0];
                default: ; // drop writes past the register list
            endcase
        end
    end

    // Input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= item.valid;
        end
    end

    // Input stage payload: capture each accepted word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg   <= item.command;
            s1_pad_reg   <= item.pad;
            s1_sum_reg   <= item.sample_sum;
            s1_fresh_reg <= item.fresh_sample;
        end
    end

    // Output stage valid: fill on advance, drain on take
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output stage payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_pad_reg   <= s1_pad_reg;
            out_event_reg <= eval_res.event_code;
        end
    end

`ifndef ASSERT_OFF
    // Calibrate words and pads outside the store always report off
    a_off_event: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_cmd_reg == ctd_pkg::CMD_CALIBRATE || !in_range))
        |=> out_event_reg == ctd_pkg::EV_OFF)
        else $error("calibrate or out-of-range pad did not report off");

    // The event carries the pad of the word that caused it
    a_pad_carry: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg && out_pad_reg == $past(s1_pad_reg))
        else $error("event pad does not match the evaluated word");

    // A zero hold limit disables timeout
    a_no_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && cfg_reg.hold_limit == '0) |=> out_event_reg != ctd_pkg::EV_TIMEOUT)
        else $error("timeout reported with hold limit zero");
`endif

endmodule

### verif/tb_capacitive_touch_detector_unit.sv
// Self-checking testbench for capacitive_touch_detector_unit: per-pad touch
// prediction, directed and random sense/calibrate words, random idling.
// Depends on ctd_pkg, the ctd_if interfaces and the detector RTL.
module tb_capacitive_touch_detector_unit;
    import ctd_pkg::*;

    localparam int PAD_COUNT    = 8;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_WORDS  = 24;

    // Index past the last register; the block must drop writes to it
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                command;
        logic [PAD_W-1:0]    pad;
        logic [SUM_W-1:0]    sample_sum;
        logic [SAMPLE_W-1:0] fresh_sample;
    } sense_word_t;

    typedef struct packed {
        logic [PAD_W-1:0] pad;
        event_t           code;
    } pad_event_t;

    logic clk;
    logic rst_n;

    ctd_in_if  in_ch();
    ctd_out_if out_ch();
    ctd_cfg_if cfg_ch();

    capacitive_touch_detector_unit #(
        .NUM_PADS(PAD_COUNT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (in_ch),
        .result(out_ch),
        .cfg   (cfg_ch)
    );

    // Words waiting to be offered, and events the detector still owes us
    sense_word_t sense_backlog[$];
    pad_event_t  pending_events[$];

    // Shadow copy of the detector: registers and per-pad state
    logic [THRESH_W-1:0] on_thr;
    logic [THRESH_W-1:0] off_thr;
    logic [HOLD_W-1:0]   hold_lim;
    logic [BASE_W-1:0]   pad_baseline[PAD_COUNT];
    logic                pad_touched[PAD_COUNT];
    logic [HOLD_W-1:0]   pad_hold[PAD_COUNT];

    // Stimulus shaping: rough per-pad level (raw sample scale) for the generator
    int gen_level[PAD_COUNT];
    int gen_last_pad;

    // Idling controls, set by the sequencer between phases
    logic tx_idle_on;
    logic rx_idle_on;
    int   tx_gap;
    int   rx_gap;
    int   hold_trigger;
    int   hold_served;
    int   rx_hold_cycles;

    // Bookkeeping
    int cycles;
    int mismatches;
    int words_sent;
    int events_seen;
    int reg_writes;
    int ev_seen[5];

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d events outstanding",
                     $time, cycles, pending_events.size());
            $display("tb_capacitive_touch_detector_unit failed");
            $finish;
        end
    end

    // Mostly no gap, sometimes a short one, now and then a long one
    function automatic int idle_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return 0;
        if (r < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 40));
    endfunction

    // Advance the shadow state by one accepted word and return the event it owes
    function automatic event_t touch_step(logic cmd, logic [PAD_W-1:0] p,
                                          logic [SUM_W-1:0] sum,
                                          logic [SAMPLE_W-1:0] fresh);
        logic [BASE_W-1:0] b;
        int                delta;
        if (int'(p) >= PAD_COUNT)
            return EV_OFF;
        b = pad_baseline[p];
        if (cmd == CMD_CALIBRATE)
        begin
            // Calibrate reloads the baseline and drops the touch, hold count stays
            pad_baseline[p] = {fresh, 8'h00};
            pad_touched[p]  = 1'b0;
            return EV_OFF;
        end
        delta = int'(sum) - int'(b >> 4);
        if (!pad_touched[p])
        begin
            if (delta > int'(on_thr))
            begin
                pad_touched[p] = 1'b1;
                pad_hold[p]    = '0;
                return EV_PUSH;
            end
            // Untouched: baseline tracks the sum through the low pass, 16-bit wrap
            pad_baseline[p] = b - (b >> 6) + {6'b0, sum[SUM_W-1:2]};
            return EV_OFF;
        end
        if (delta < int'(off_thr))
        begin
            pad_touched[p] = 1'b0;
            return EV_RELEASE;
        end
        // Only equality trips the timeout; a zero limit disables it
        if (hold_lim != '0 && pad_hold[p] == hold_lim)
        begin
            pad_baseline[p] = {fresh, 8'h00};
            return EV_TIMEOUT;
        end
        pad_hold[p] = pad_hold[p] + 1'b1;
        return EV_ON;
    endfunction

    // Well-formed random word: sums sit around the pad's level, offset so that
    // pushes, holds, releases and drift all come up regularly
    function automatic sense_word_t random_word(int on_level);
        sense_word_t w;
        int          p;
        int          r;
        int          offs;
        int          s;
        r = int'($urandom_range(0, 99));
        if ($urandom_range(0, 1) == 0)
            p = gen_last_pad;
        else
            p = int'($urandom_range(0, PAD_COUNT - 1));
        gen_last_pad = p;
        w.pad = PAD_W'(p);
        if (r < 8)
        begin
            w.command      = CMD_CALIBRATE;
            w.fresh_sample = SAMPLE_W'($urandom_range(0, 255));
            w.sample_sum   = SUM_W'($urandom_range(0, 4080));
            gen_level[p]   = int'(w.fresh_sample);
            return w;
        end
        w.command = CMD_SENSE;
        r = int'($urandom_range(0, 99));
        if (r < 40)
            offs = int'($urandom_range(0, 16)) - 8;
        else if (r < 65)
            offs = on_level + int'($urandom_range(0, 4)) - 2;
        else if (r < 85)
            offs = int'($urandom_range(64, 600));
        else
            offs = -int'($urandom_range(8, 300));
        s = gen_level[p] * 16 + offs;
        if ($urandom_range(0, 19) == 0)
            s = int'($urandom_range(0, 4080));
        if (s < 0)
            s = 0;
        if (s > 4080)
            s = 4080;
        w.sample_sum = SUM_W'(s);
        if ($urandom_range(0, 9) == 0)
            w.fresh_sample = SAMPLE_W'($urandom_range(0, 255));
        else
            w.fresh_sample = SAMPLE_W'(gen_level[p]);
        return w;
    endfunction

    // Input driver: predict on every accepted word, then offer the next one
    always @(posedge clk)
    begin : tx_driver
        sense_word_t w;
        event_t      ev;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                ev = touch_step(in_ch.command, in_ch.pad, in_ch.sample_sum,
                                in_ch.fresh_sample);
                pending_events.push_back('{pad: in_ch.pad, code: ev});
                words_sent++;
            end
            // The slot is free once the current word is gone or none is up
            if (!in_ch.valid || in_ch.ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap--;
                    in_ch.valid <= 1'b0;
                end
                else if (sense_backlog.size() != 0)
                begin
                    w = sense_backlog.pop_front();
                    in_ch.valid        <= 1'b1;
                    in_ch.command      <= w.command;
                    in_ch.pad          <= w.pad;
                    in_ch.sample_sum   <= w.sample_sum;
                    in_ch.fresh_sample <= w.fresh_sample;
                    tx_gap = tx_idle_on ? idle_gap() : 0;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here so the monitor only sees a flag
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rx_hold_cycles <= 0;
            hold_served    <= 0;
        end
        else if (rx_hold_cycles != 0)
        begin
            rx_hold_cycles <= rx_hold_cycles - 1;
        end
        else if (hold_served != hold_trigger)
        begin
            rx_hold_cycles <= LONG_HOLD;
            hold_served    <= hold_trigger;
        end
    end

    // Output monitor: match each event word against the oldest expectation
    always @(posedge clk)
    begin : rx_monitor
        pad_event_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t: unexpected event word: expected none, got pad %0d event %0d",
                             $time, out_ch.pad_out, out_ch.event_res);
                    mismatches++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (out_ch.pad_out !== want.pad)
                    begin
                        $display("%0t: pad_out mismatch: expected %0d, got %0d",
                                 $time, want.pad, out_ch.pad_out);
                        mismatches++;
                    end
                    if (out_ch.event_res !== want.code)
                    begin
                        $display("%0t: event_res mismatch on pad %0d: expected %0d, got %0d",
                                 $time, want.pad, want.code, out_ch.event_res);
                        mismatches++;
                    end
                    ev_seen[want.code]++;
                    events_seen++;
                end
            end
            if (rx_hold_cycles != 0)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (rx_gap != 0)
            begin
                rx_gap--;
                out_ch.ready <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                rx_gap = idle_gap();
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic offer_word(logic cmd, int p, int sum, int fresh);
        sense_word_t w;
        w.command      = cmd;
        w.pad          = PAD_W'(p);
        w.sample_sum   = SUM_W'(sum);
        w.fresh_sample = SAMPLE_W'(fresh);
        sense_backlog.push_back(w);
    endtask

    // Hold the sequencer until every offered word has come back as an event,
    // then let the pipeline settle before touching registers
    task automatic wait_idle();
        do
            @(negedge clk);
        while (sense_backlog.size() != 0 || in_ch.valid || pending_events.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // One register write; the shadow copy follows at the accepting edge
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_ON_THRESHOLD:  on_thr   = value;
            REG_OFF_THRESHOLD: off_thr  = value;
            REG_HOLD_LIMIT:    hold_lim = value[HOLD_W-1:0];
            default: ;
        endcase
        reg_writes++;
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(int on_value, int off_value, int hold_value);
        write_reg(REG_ON_THRESHOLD, CFG_DATA_W'(on_value));
        write_reg(REG_OFF_THRESHOLD, CFG_DATA_W'(off_value));
        write_reg(REG_HOLD_LIMIT, CFG_DATA_W'(hold_value));
    endtask

    // Sequencer: directed checks, hold-count wrap, then random phases
    initial
    begin : sequencer
        int i;
        int ph;
        int on_value;
        int off_value;
        int hold_value;

        // Known values on every input from time zero
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.command      = CMD_SENSE;
        in_ch.pad          = '0;
        in_ch.sample_sum   = '0;
        in_ch.fresh_sample = '0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = REG_ON_THRESHOLD;
        cfg_ch.data        = '0;
        cycles             = 0;
        mismatches         = 0;
        words_sent         = 0;
        events_seen        = 0;
        reg_writes         = 0;
        hold_trigger       = 0;
        gen_last_pad       = 0;
        tx_idle_on         = 1'b1;
        rx_idle_on         = 1'b1;
        for (i = 0; i < 5; i++)
            ev_seen[i] = 0;
        on_thr   = ON_THRESHOLD_RST;
        off_thr  = OFF_THRESHOLD_RST;
        hold_lim = HOLD_LIMIT_RST;
        for (i = 0; i < PAD_COUNT; i++)
        begin
            pad_baseline[i] = '0;
            pad_touched[i]  = 1'b0;
            pad_hold[i]     = '0;
            gen_level[i]    = 0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset thresholds: edges of push and release on a zero baseline
        offer_word(CMD_SENSE, 0, 0, 0);          // off
        offer_word(CMD_SENSE, 0, 2, 0);          // delta equals on threshold: off
        offer_word(CMD_SENSE, 0, 3, 0);          // push
        offer_word(CMD_SENSE, 0, 1, 0);          // delta equals off threshold: on
        offer_word(CMD_SENSE, 0, 0, 0);          // release
        // Top of the ranges: full baseline, full sums
        offer_word(CMD_CALIBRATE, 7, 4080, 255); // calibrate, off
        offer_word(CMD_SENSE, 7, 0, 255);        // far below baseline: off, drift
        offer_word(CMD_CALIBRATE, 7, 4080, 254);
        offer_word(CMD_SENSE, 7, 4080, 254);     // push
        offer_word(CMD_SENSE, 7, 4080, 170);     // on
        offer_word(CMD_CALIBRATE, 7, 1365, 85);  // calibrate while touched
        offer_word(CMD_SENSE, 7, 4080, 85);      // fresh touch after calibrate
        // Alternating bit patterns on the other pads
        offer_word(CMD_SENSE, 3, 2047, 85);
        offer_word(CMD_SENSE, 3, 1365, 170);
        offer_word(CMD_SENSE, 4, 2730, 15);
        offer_word(CMD_CALIBRATE, 1, 3855, 240);
        offer_word(CMD_SENSE, 1, 240, 15);
        offer_word(CMD_SENSE, 2, 4080, 0);
        wait_idle();

        // Zero thresholds, short hold limit: reach timeout quickly, and check
        // that a write past the last register is dropped
        apply_settings(0, 0, 2);
        write_reg(REG_UNUSED, 12'hABC);
        offer_word(CMD_SENSE, 5, 1, 0);          // push
        offer_word(CMD_SENSE, 5, 1, 0);          // on
        offer_word(CMD_SENSE, 5, 1, 0);          // on
        offer_word(CMD_SENSE, 5, 1, 0);          // timeout
        offer_word(CMD_SENSE, 5, 0, 0);          // timeout again, count kept
        wait_idle();

        // Timeout disabled: a zero count against a zero limit must not trip.
        // Then a limit below the current count (upper data bits set, dropped
        // by the register) has to wrap the count through zero before it trips.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_reg(REG_HOLD_LIMIT, 12'd0);
        offer_word(CMD_SENSE, 6, 100, 0);        // push
        offer_word(CMD_SENSE, 6, 100, 0);        // on, count zero
        offer_word(CMD_SENSE, 6, 100, 0);        // on
        wait_idle();
        write_reg(REG_HOLD_LIMIT, 12'hF01);
        for (i = 0; i < 257; i++)
            offer_word(CMD_SENSE, 6, 100, 0);
        wait_idle();

        // Random phases, each under its own register setting
        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    on_value   = 4095;
                    off_value  = 4095;
                    hold_value = 0;
                end
                1:
                begin
                    on_value   = 0;
                    off_value  = 0;
                    hold_value = 1;
                end
                2:
                begin
                    on_value   = int'($urandom_range(1, 40));
                    off_value  = int'($urandom_range(0, on_value));
                    hold_value = int'($urandom_range(2, 10));
                end
                3:
                begin
                    on_value   = int'($urandom_range(0, 4095));
                    off_value  = int'($urandom_range(0, 4095));
                    hold_value = int'($urandom_range(0, 255));
                end
                default:
                begin
                    on_value   = int'(ON_THRESHOLD_RST);
                    off_value  = int'(OFF_THRESHOLD_RST);
                    hold_value = int'(HOLD_LIMIT_RST);
                end
            endcase
            apply_settings(on_value, off_value, hold_value);
            // First phase runs flat out on both sides; the rest idle at random
            tx_idle_on = (ph != 0);
            rx_idle_on = (ph != 0);
            for (i = 0; i < PHASE_WORDS; i++)
                sense_backlog.push_back(random_word(on_value));
            // Stall the output long enough for the detector to back up its input
            if (ph == 1)
                hold_trigger++;
            wait_idle();
        end

        if (pending_events.size() != 0)
        begin
            $display("%0t: %0d events never arrived: expected pad %0d event %0d first",
                     $time, pending_events.size(), pending_events[0].pad,
                     pending_events[0].code);
            mismatches += pending_events.size();
        end

        $display("Covered %0d words, %0d events (off %0d, on %0d, push %0d, release %0d, timeout %0d),",
                 words_sent, events_seen, ev_seen[EV_OFF], ev_seen[EV_ON], ev_seen[EV_PUSH],
                 ev_seen[EV_RELEASE], ev_seen[EV_TIMEOUT]);
        $display("%0d register writes, %0d mismatches, %0d cycles",
                 reg_writes, mismatches, cycles);
        if (mismatches == 0)
            $display("tb_capacitive_touch_detector_unit passed");
        else
            $display("tb_capacitive_touch_detector_unit failed");
        $finish;
    end

endmodule
